>>> design/hmm_pkg.sv
// Package: shared constants and command codes for the HMM forward filter.
`default_nettype none
package hmm_pkg;
  localparam int MaxStatesDef  = 8;
  localparam int MaxSymbolsDef = 256;
  localparam int ProbBitsDef   = 16;
  localparam int CmdW  = 2;
  localparam int SiW   = 3;
  localparam int ColW  = 8;
  localparam int ValW  = 16;
  localparam int CntW  = 4;

  localparam logic [CmdW-1:0] CmdInit  = 2'd0;
  localparam logic [CmdW-1:0] CmdTrans = 2'd1;
  localparam logic [CmdW-1:0] CmdEmit  = 2'd2;
  localparam logic [CmdW-1:0] CmdObs   = 2'd3;
endpackage
`default_nettype wire

>>> design/hmm_ram.sv
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module hmm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> design/hmm_cell.sv
// One state cell: holds its forward value, accumulates its prediction and term.
`default_nettype none
module hmm_cell #(
  parameter int ProbBits = 16,
  parameter int NStates  = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clr_i,      // start accumulation
  input  wire logic                    mac_i,      // add trans*fwd_in
  input  wire logic [ProbBits-1:0]     trans_i,
  input  wire logic [ProbBits-1:0]     fwd_in_i,   // forward value passed along chain
  input  wire logic                    term_i,     // form term from base and emission
  input  wire logic                    first_i,
  input  wire logic [ProbBits-1:0]     init_i,
  input  wire logic [ProbBits-1:0]     emit_i,
  input  wire logic                    rot_i,      // rotate forward values
  input  wire logic                    load_i,     // write new forward value
  input  wire logic [ProbBits-1:0]     fwd_new_i,
  input  wire logic [ProbBits-1:0]     fwd_prev_i, // neighbour value during rotation
  output logic      [ProbBits-1:0]     fwd_o,
  output logic      [2*ProbBits+$clog2(NStates)-1:0] term_o
);
  localparam int AccW  = 2*ProbBits + $clog2(NStates);
  localparam int BaseW = ProbBits + $clog2(NStates);
  localparam int TermW = BaseW + ProbBits;
  logic [AccW-1:0]       acc_q;
  logic [2*ProbBits-1:0] prod_q;
  logic [TermW-1:0]      term_q;
  logic                  mac_q;
  logic [ProbBits-1:0]   fwd_q;
  logic [BaseW-1:0]      base;

  always_ff @(posedge clk_i) begin
    prod_q <= trans_i * fwd_in_i;
    if (clr_i) begin
      acc_q <= '0;
    end else if (mac_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (term_i) begin
      term_q <= base * emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= 1'b0;
      fwd_q <= '0;
    end else begin
      mac_q <= mac_i;
      if (load_i) begin
        fwd_q <= fwd_new_i;
      end else if (rot_i) begin
        fwd_q <= fwd_prev_i;
      end
    end
  end

  // keep every bit of the prediction: it can exceed one unit
  assign base   = first_i ? BaseW'(init_i) : acc_q[AccW-1:ProbBits];
  assign fwd_o  = fwd_q;
  assign term_o = term_q;
endmodule
`default_nettype wire

>>> design/hmm_div.sv
// Restoring divider: floor(num * 2^ProbBits / den), saturating when num >= den; one quotient bit a cycle.
`default_nettype none
module hmm_div #(
  parameter int ProbBits = 16,
  parameter int DenW     = 35
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DenW-1:0]      num_i,
  input  wire logic [DenW-1:0]      den_i,
  output logic                      done_o,
  output logic      [ProbBits-1:0]  quot_o
);
  localparam int CW = $clog2(ProbBits + 1);
  logic [DenW-1:0]       r_q;
  logic [DenW:0]         r2;
  logic [DenW-1:0]       den_q;
  logic [ProbBits-1:0]   q_q;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q, done_q, sat_q;

  assign r2 = {r_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= num_i;
      den_q <= den_i;
      q_q   <= '0;
      sat_q <= (num_i >= den_i);
    end else if (busy_q) begin
      if (r2 >= {1'b0, den_q}) begin
        r_q <= DenW'(r2 - {1'b0, den_q});
        q_q <= {q_q[ProbBits-2:0], 1'b1};
      end else begin
        r_q <= r2[DenW-1:0];
        q_q <= {q_q[ProbBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ProbBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? {ProbBits{1'b1}} : q_q;
endmodule
`default_nettype wire

>>> design/hmm_scaled_forward_filter.sv
// Top level: HMM scaled forward filter with a chain of state cells.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid_i/in_stall_o  | cmd, state_index, column_index, ...
//  out     | output    | out_valid_o/out_stall_i| state_out, filtered_prob, all_zero, last
//  cfg     | input     | cfg_we_i               | cfg_data_i (active_states)
//
// Write items are taken while idle. An observe is accepted, then runs the
// transition MACs (values rotate round the cell chain, each cell taking its
// entries from its own column), then reads emissions and sums the terms, then
// per state starts the divider, forms the quotient bits, flags completion and
// hands over the result. Reset clears the forward values; the tables need no
// clearing. A stalled result holds the block.
`default_nettype none
module hmm_scaled_forward_filter #(
  parameter int MAX_STATES  = hmm_pkg::MaxStatesDef,
  parameter int MAX_SYMBOLS = hmm_pkg::MaxSymbolsDef,
  parameter int PROB_BITS   = hmm_pkg::ProbBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [hmm_pkg::CntW-1:0]  cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [hmm_pkg::CmdW-1:0]  cmd_i,
  input  wire logic [hmm_pkg::SiW-1:0]   state_index_i,
  input  wire logic [hmm_pkg::ColW-1:0]  column_index_i,
  input  wire logic [hmm_pkg::ValW-1:0]  prob_value_i,
  input  wire logic [hmm_pkg::ColW-1:0]  symbol_i,
  input  wire logic                      first_of_sequence_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic      [hmm_pkg::SiW-1:0]   state_out_o,
  output logic      [hmm_pkg::ValW-1:0]  filtered_prob_o,
  output logic                           all_zero_o,
  output logic                           last_o
);
  import hmm_pkg::*;

  localparam int N   = MAX_STATES;
  localparam int NW  = $clog2(N);
  localparam int SW  = $clog2(MAX_SYMBOLS);
  localparam int PB  = PROB_BITS;
  localparam int TW  = 2*PB + NW;
  localparam int SUMW = TW + NW;
  localparam int CW  = NW + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMac  = 3'd1;
  localparam logic [2:0] StEmit = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StWait = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] nact_q;
  logic          first_q;
  logic          sym_ok_q;
  logic [SW-1:0] sym_q;
  logic [SUMW-1:0] sum_q;

  // active count, clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nact_q <= CW'(N);
    end else if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        nact_q <= CW'(1);
      end else if (32'(cfg_data_i) > N) begin
        nact_q <= CW'(N);
      end else begin
        nact_q <= CW'(cfg_data_i);
      end
    end
  end

  logic accept;
  assign in_stall_o = (st_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  // table stores
  logic [PB-1:0] init_q [N];
  logic [PB-1:0] wval;
  assign wval = PB'(prob_value_i);

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CmdInit && 32'(state_index_i) < N) begin
      init_q[NW'(state_index_i)] <= wval;
    end
  end

  logic emit_we;
  logic [$clog2(N*MAX_SYMBOLS)-1:0] emit_wa, emit_ra;
  logic [PB-1:0] emit_rd;
  assign emit_we = accept && cmd_i == CmdEmit && 32'(state_index_i) < N
                   && 32'(column_index_i) < MAX_SYMBOLS;
  assign emit_wa = {NW'(state_index_i), SW'(column_index_i)};
  assign emit_ra = {k_q[NW-1:0], sym_q};

  hmm_ram #(.Width(PB), .Depth(N*MAX_SYMBOLS)) u_emit (
    .clk_i  (clk_i),
    .we_i   (emit_we),
    .waddr_i(emit_wa),
    .wdata_i(wval),
    .raddr_i(emit_ra),
    .rdata_o(emit_rd)
  );

  // chain of cells; forward values rotate so cell k sees fwd[(k+l) mod K] at step l
  logic [PB-1:0] fwd [N];
  logic [TW-1:0] term [N];
  logic [PB-1:0] rot_src [N];
  logic [PB-1:0] tr_fix [N];
  logic [PB-1:0] q;
  logic          div_done;
  logic          clr, mac, rot, emit_v_q;
  logic [NW-1:0] lidx;
  logic [CW-1:0] emit_k_q;
  logic          add_v_q;
  logic [NW-1:0] add_k_q;

  assign clr  = accept && cmd_i == CmdObs;
  assign mac  = (st_q == StMac) && (cnt_q < nact_q);
  assign rot  = mac;
  assign lidx = cnt_q[NW-1:0];

  genvar g;

  // each cell keeps its own column of the transition matrix;
  // cell k at step l holds fwd[(k+l) mod K] and needs trans[(k+l) mod K][k]
  generate
    for (g = 0; g < N; g++) begin : g_row
      logic [PB-1:0] col_q [N];
      logic [CW:0]   r;
      always_ff @(posedge clk_i) begin
        if (accept && cmd_i == CmdTrans && 32'(state_index_i) < N
            && 32'(column_index_i) == 32'(g)) begin
          col_q[NW'(state_index_i)] <= wval;
        end
      end
      assign r = (CW+1)'(g) + (CW+1)'(lidx);
      assign tr_fix[g] = col_q[(r >= (CW+1)'(nact_q)) ? NW'(r - (CW+1)'(nact_q))
                                                      : NW'(r)];
    end
  endgenerate

  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic ld, tm;
      // ring over active states: cell k takes k+1, last active wraps to cell 0
      assign rot_src[g] = (32'(g) + 1 >= 32'(nact_q)) ? fwd[0] : fwd[(g + 1) % N];
      assign ld = div_done && (k_q == CW'(g));
      assign tm = emit_v_q && (emit_k_q == CW'(g));
      hmm_cell #(.ProbBits(PB), .NStates(N)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .clr_i     (clr),
        .mac_i     (mac),
        .trans_i   (tr_fix[g]),
        .fwd_in_i  (fwd[g]),
        .term_i    (tm),
        .first_i   (first_q),
        .init_i    (init_q[g]),
        .emit_i    (sym_ok_q ? emit_rd : '0),
        .rot_i     (rot && 32'(g) < 32'(nact_q)),
        .load_i    (ld),
        .fwd_new_i (sum_q == '0 ? '0 : q),
        .fwd_prev_i(rot_src[g]),
        .fwd_o     (fwd[g]),
        .term_o    (term[g])
      );
    end
  endgenerate

  // divider
  logic div_start;
  logic [SUMW-1:0] num_sel;
  assign num_sel = SUMW'(term[k_q[NW-1:0]]);
  hmm_div #(.ProbBits(PB), .DenW(SUMW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_sel),
    .den_i  (sum_q),
    .done_o (div_done),
    .quot_o (q)
  );

  logic [PB-1:0] res_q;
  always_ff @(posedge clk_i) begin
    if (clr) begin
      first_q  <= first_of_sequence_i;
      sym_ok_q <= 32'(symbol_i) < MAX_SYMBOLS;
      sym_q    <= SW'(symbol_i);
    end
    if (div_done) begin
      res_q <= (sum_q == '0) ? '0 : q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cnt_q    <= '0;
      k_q      <= '0;
      emit_v_q <= 1'b0;
      emit_k_q <= '0;
      add_v_q  <= 1'b0;
      add_k_q  <= '0;
      sum_q    <= '0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      emit_v_q <= (st_q == StEmit) && (k_q < nact_q);
      emit_k_q <= k_q;
      // a term lands in the cycle after its emission read returns
      add_v_q  <= emit_v_q;
      add_k_q  <= emit_k_q[NW-1:0];
      if (st_q == StEmit && k_q == '0) begin
        sum_q <= '0;
      end else if (add_v_q) begin
        sum_q <= sum_q + SUMW'(term[add_k_q]);
      end
    end
  end

  assign div_start = (st_q == StDiv);

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    k_d   = k_q;
    case (st_q)
      StIdle: begin
        if (clr) begin
          cnt_d = '0;
          st_d  = StMac;
        end
      end
      StMac: begin
        // two extra steps drain the multiplier register
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == nact_q + CW'(1)) begin
          k_d  = '0;
          st_d = StEmit;
        end
      end
      StEmit: begin
        k_d = k_q + 1'b1;
        if (k_q == nact_q) begin
          st_d = StSum;
        end
      end
      StSum: begin
        // hold until the last term is in the sum
        if (!emit_v_q && !add_v_q) begin
          k_d  = '0;
          st_d = StDiv;
        end
      end
      StDiv:  st_d = StWait;
      StWait: if (div_done) st_d = StOut;
      StOut: begin
        if (!out_stall_i) begin
          k_d = k_q + 1'b1;
          st_d = (k_q + 1'b1 == nact_q) ? StIdle : StDiv;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o     = (st_q == StOut);
  assign state_out_o     = SiW'(k_q);
  assign filtered_prob_o = ValW'(res_q);
  assign all_zero_o      = (sum_q == '0);
  assign last_o          = (k_q + 1'b1 == nact_q);

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> in_stall_o) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(filtered_prob_o)))
    else $error("stalled result changed");
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (k_q < nact_q)) else $error("result state out of range");
endmodule
`default_nettype wire

>>> test/hmm_scaled_forward_filter_tb.sv
// Testbench for the scaled HMM forward filter: table stimulus, random sequences, model check.
`timescale 1ns / 100ps
`default_nettype none
module hmm_scaled_forward_filter_tb;
  import hmm_pkg::*;

  localparam int NS = MaxStatesDef;
  localparam int NV = MaxSymbolsDef;
  localparam int PB = ProbBitsDef;
  localparam longint unsigned PMAX = (64'd1 << PB) - 1;
  localparam int WDOG_LIMIT = 3000;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [SiW-1:0]  si;
    logic [ColW-1:0] col;
    logic [ValW-1:0] val;
    logic [ColW-1:0] sym;
    logic            first;
  } hmm_item_t;

  typedef struct packed {
    logic [SiW-1:0]  st;
    logic [ValW-1:0] prob;
    logic            zero;
    logic            last;
  } filt_res_t;

  typedef struct {
    int        new_k;    // -1 keeps the current state count
    hmm_item_t it;
    bit        typed;
    logic [ValW-1:0] t_prob;
    logic      t_zero;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CntW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [CmdW-1:0] cmd_i = '0;
  logic [SiW-1:0] state_index_i = '0;
  logic [ColW-1:0] column_index_i = '0;
  logic [ValW-1:0] prob_value_i = '0;
  logic [ColW-1:0] symbol_i = '0;
  logic first_of_sequence_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SiW-1:0] state_out_o;
  logic [ValW-1:0] filtered_prob_o;
  logic all_zero_o;
  logic last_o;

  hmm_scaled_forward_filter dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .cmd_i, .state_index_i, .column_index_i, .prob_value_i, .symbol_i,
    .first_of_sequence_i, .out_valid_o, .out_stall_i, .state_out_o,
    .filtered_prob_o, .all_zero_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's tables and forward vector
  logic [ValW-1:0] pi_t [NS];
  logic [ValW-1:0] a_t [NS][NS];
  logic [ValW-1:0] b_t [NS][NV];
  bit              b_wr [NS][NV];
  logic [ValW-1:0] fwd [NS];
  logic [CntW-1:0] k_reg = 4'd8;

  filt_res_t filt_q [$];
  int errors = 0;
  int shown = 0;
  int idle_cnt = 0;
  bit quiet = 1'b0;
  bit started = 1'b0;

  function automatic longint unsigned norm_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = num;
    if (r >= den) return PMAX;
    for (int i = 0; i < PB; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return (q > PMAX) ? PMAX : q;
  endfunction

  function automatic int states_used();
    if (k_reg == 0) return 1;
    if (k_reg > NS) return NS;
    return int'(k_reg);
  endfunction

  // Update the shadow state for one accepted item; for an observe, queue its filtered vector
  function automatic void filter_step(hmm_item_t it);
    longint unsigned term [NS];
    longint unsigned sum, acc, base, e, p;
    filt_res_t r;
    int n;
    sum = 0;
    n = states_used();
    case (it.cmd)
      CmdInit: pi_t[it.si] = it.val;
      CmdTrans: if (it.col < NS) a_t[it.si][it.col] = it.val;
      CmdEmit: begin
        b_t[it.si][it.col] = it.val;
        b_wr[it.si][it.col] = 1'b1;
      end
      default: begin
        for (int k = 0; k < n; k++) begin
          e = b_t[k][it.sym];
          if (it.first) begin
            base = pi_t[k];
          end else begin
            acc = 0;
            for (int l = 0; l < n; l++) acc += longint'(a_t[l][k]) * longint'(fwd[l]);
            base = acc >> PB;
          end
          term[k] = base * e;
          sum += term[k];
        end
        for (int k = 0; k < n; k++) begin
          p = (sum != 0) ? norm_ratio(term[k], sum) : 0;
          fwd[k] = p[ValW-1:0];
          r.st = k[SiW-1:0];
          r.prob = p[ValW-1:0];
          r.zero = (sum == 0);
          r.last = (k == n - 1);
          filt_q.push_back(r);
        end
      end
    endcase
  endfunction

  task automatic send_item(hmm_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= it.cmd;
    state_index_i <= it.si;
    column_index_i <= it.col;
    prob_value_i <= it.val;
    symbol_i <= it.sym;
    first_of_sequence_i <= it.first;
    do @(posedge clk_i); while (in_stall_o);
    filter_step(it);
  endtask

  // Drain all results, let a trailing write settle, then set the state count
  task automatic set_states(logic [CntW-1:0] v);
    in_valid_i <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_reg = v;
  endtask

  function automatic hmm_item_t mk(logic [CmdW-1:0] c, int si, int col, int val,
                                   int sym, bit first);
    hmm_item_t it;
    it.cmd = c;
    it.si = si[SiW-1:0];
    it.col = col[ColW-1:0];
    it.val = val[ValW-1:0];
    it.sym = sym[ColW-1:0];
    it.first = first;
    return it;
  endfunction

  function automatic logic [ColW-1:0] pick_symbol();
    int s;
    bit ok;
    do begin
      s = $urandom_range(0, NV - 1);
      ok = 1'b1;
      for (int k = 0; k < NS; k++) if (!b_wr[k][s]) ok = 1'b0;
    end while (!ok);
    return s[ColW-1:0];
  endfunction

  function automatic hmm_item_t rand_write();
    hmm_item_t it;
    int c;
    c = $urandom_range(0, 2);
    it = mk(c[CmdW-1:0], $urandom_range(0, NS - 1), $urandom_range(0, 255),
            $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 1) == 1);
    if (it.cmd == CmdTrans && $urandom_range(0, 3) != 0)
      it.col = ColW'($urandom_range(0, NS - 1));
    if ($urandom_range(0, 9) == 0) it.val = '0;
    return it;
  endfunction

  // Result side: random stalls, compare against the oldest expectation
  initial begin
    int n;
    filt_res_t e;
    wait (started);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (filt_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected item: state %0d prob %h", state_out_o, filtered_prob_o);
        end
      end else begin
        e = filt_q.pop_front();
        if (state_out_o !== e.st || filtered_prob_o !== e.prob ||
            all_zero_o !== e.zero || last_o !== e.last) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("mismatch: exp st %0d p %h z %b l %b, got st %0d p %h z %b l %b",
                     e.st, e.prob, e.zero, e.last,
                     state_out_o, filtered_prob_o, all_zero_o, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    row_t rw;
    int base;
    int syms [6];
    logic [CntW-1:0] phase_k [5];
    hmm_item_t it;
    int len;

    syms = '{0, 1, 255, 85, 170, 128};
    phase_k = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd1};
    for (int k = 0; k < NS; k++) begin
      fwd[k] = '0;
      pi_t[k] = '0;
      for (int j = 0; j < NS; j++) a_t[k][j] = '0;
      for (int v = 0; v < NV; v++) begin
        b_t[k][v] = '0;
        b_wr[k][v] = 1'b0;
      end
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    started = 1'b1;

    // Load every entry that an observe may read
    for (int k = 0; k < NS; k++)
      send_item(mk(CmdInit, k, 0, (k == 0) ? 65535 : $urandom_range(1, 65535), 0, 0));
    for (int l = 0; l < NS; l++)
      for (int k = 0; k < NS; k++)
        send_item(mk(CmdTrans, l, k, $urandom_range(0, 65535), 0, 0));
    foreach (syms[i])
      for (int k = 0; k < NS; k++)
        send_item(mk(CmdEmit, k, syms[i],
                     (syms[i] == 0) ? 65535 : (syms[i] == 1) ? 0 : $urandom_range(0, 65535),
                     0, 0));

    // Directed rows
    rw.typed = 1'b0; rw.t_prob = '0; rw.t_zero = 1'b0; rw.new_k = -1;
    // continuation straight after reset: zero vector, zero normaliser
    rw.it = mk(CmdObs, 0, 0, 0, 0, 0); rw.typed = 1; rw.t_prob = 0; rw.t_zero = 1;
    rows.push_back(rw);
    rw.typed = 0;
    rw.it = mk(CmdObs, 7, 255, 65535, 85, 1); rows.push_back(rw);
    rw.it = mk(CmdObs, 0, 0, 0, 170, 0); rows.push_back(rw);
    rw.it = mk(CmdObs, 0, 0, 0, 255, 0); rows.push_back(rw);
    // all emissions zero for this symbol, then continue from the cleared vector
    rw.it = mk(CmdObs, 0, 0, 0, 1, 1); rw.typed = 1; rw.t_prob = 0; rw.t_zero = 1;
    rows.push_back(rw);
    rw.it = mk(CmdObs, 0, 0, 0, 0, 0); rows.push_back(rw);
    // one state: the ratio saturates at full scale
    rw.new_k = 1; rw.it = mk(CmdObs, 0, 0, 0, 0, 1); rw.t_prob = 16'hFFFF; rw.t_zero = 0;
    rows.push_back(rw);
    rw.new_k = -1; rw.typed = 0;
    rw.it = mk(CmdObs, 0, 0, 0, 128, 0); rows.push_back(rw);
    rw.new_k = 15; rw.it = mk(CmdObs, 0, 0, 0, 128, 1); rows.push_back(rw);
    rw.new_k = -1;
    rw.it = mk(CmdObs, 0, 0, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdTrans, 3, 200, 65535, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdTrans, 7, 8, 65535, 0, 1); rows.push_back(rw);
    rw.it = mk(CmdTrans, 7, 7, 65535, 255, 1); rows.push_back(rw);
    rw.it = mk(CmdInit, 7, 255, 0, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdEmit, 7, 255, 65535, 0, 0); rows.push_back(rw);
    rw.it = mk(CmdObs, 0, 0, 0, 255, 0); rows.push_back(rw);
    rw.new_k = 0; rw.it = mk(CmdObs, 0, 0, 0, 255, 1); rows.push_back(rw);
    rw.new_k = -1;
    rw.it = mk(CmdObs, 0, 0, 0, 85, 0); rows.push_back(rw);

    foreach (rows[i]) begin
      if (rows[i].new_k >= 0) set_states(rows[i].new_k[CntW-1:0]);
      base = filt_q.size();
      send_item(rows[i].it);
      if (rows[i].typed)
        for (int j = base; j < filt_q.size(); j++) begin
          filt_q[j].prob = rows[i].t_prob;
          filt_q[j].zero = rows[i].t_zero;
        end
    end

    // Random phases: mostly sequences of observes, with writes mixed in
    foreach (phase_k[p]) begin
      set_states((p == 4) ? CntW'($urandom_range(0, 15)) : phase_k[p]);
      quiet = (p == 2);
      len = 0;
      while (len < 18) begin
        if ($urandom_range(0, 4) == 0) begin
          it = rand_write();
          send_item(it);
        end else begin
          send_item(mk(CmdObs, $urandom_range(0, 7), $urandom_range(0, 255),
                       $urandom_range(0, 65535), pick_symbol(), 1));
          repeat ($urandom_range(1, 6)) begin
            send_item(mk(CmdObs, $urandom_range(0, 7), $urandom_range(0, 255),
                         $urandom_range(0, 65535), pick_symbol(), $urandom_range(0, 9) == 0));
            len++;
          end
        end
        len++;
      end
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/hmm_pkg.sv
design/hmm_ram.sv
design/hmm_cell.sv
design/hmm_div.sv
design/hmm_scaled_forward_filter.sv
test/hmm_scaled_forward_filter_tb.sv
